/* hw/rtl/ghbp_pkg.sv */
// ----------------------------------------------------------------------------
// ghbp_pkg
// Shared constants, types and the counter update function of the global
// history branch predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ghbp_pkg;

    localparam int PC_INDEX_BITS = 8;
    localparam int HISTORY_BITS  = 4;
    localparam int TABLE_BITS    = HISTORY_BITS + PC_INDEX_BITS;
    localparam int TABLE_DEPTH   = 1 << TABLE_BITS;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 8;

    localparam logic [1:0] CNT_STRONG_NT = 2'd0;
    localparam logic [1:0] CNT_WEAK_NT   = 2'd1;
    localparam logic [1:0] CNT_WEAK_T    = 2'd2;
    localparam logic [1:0] CNT_STRONG_T  = 2'd3;

    typedef struct packed {
        logic [TABLE_BITS-1:0] idx;
        logic                  taken;
    } ghbp_entry_t;

    typedef struct packed {
        logic vld;
        logic full;
    } ghbp_q_status_t;

    function automatic logic [1:0] ghbp_next_counter(input logic [1:0] c, input logic taken);
        logic [1:0] n;
        if (c[1] == taken) begin
            if (taken) begin
                n = (c == CNT_STRONG_T) ? CNT_STRONG_T : c + 2'd1;
            end
            else begin
                n = (c == CNT_STRONG_NT) ? CNT_STRONG_NT : c - 2'd1;
            end
        end
        else begin
            if (taken) begin
                n = (c == CNT_WEAK_NT) ? CNT_STRONG_T : CNT_WEAK_NT;
            end
            else begin
                n = (c == CNT_WEAK_T) ? CNT_STRONG_NT : CNT_WEAK_T;
            end
        end
        return n;
    endfunction

endpackage

/* hw/rtl/global_history_branch_predictor_core.sv */
// ----------------------------------------------------------------------------
// global_history_branch_predictor_core
// Two-level global history branch predictor with 2-bit counters.
// ----------------------------------------------------------------------------
// The block takes one resolved branch per transaction and returns one
// prediction per transaction, in order, at a sustained rate of one
// transaction per clock cycle when the output is not stalled; the result
// passes through the queue, the table read stage and the output buffer.
// The rate is set by the single read-modify-write of the counter table per
// branch, with forwarding between back-to-back updates. After reset the
// block first writes every one of the 4096 table entries to strongly taken,
// one entry per cycle, and holds s_axis_tready low until that is done.
`timescale 1ns / 1ps

module global_history_branch_predictor_core
    import ghbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // branch_pc[31:0], actual_taken[32], zeros
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // predicted_taken[0], zeros
);

    logic           busy;
    logic           push;
    logic           pop;
    ghbp_entry_t    push_entry;
    ghbp_entry_t    pop_entry;
    ghbp_q_status_t q_stat;

    ghbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .busy          (busy),
        .q_stat        (q_stat),
        .push          (push),
        .push_entry    (push_entry)
    );

    ghbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    ghbp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_entry       (pop_entry),
        .pop           (pop),
        .busy          (busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* hw/rtl/ghbp_front.sv */
// ----------------------------------------------------------------------------
// ghbp_front
// Accepts resolved branches, forms the table index from the global history
// and the low PC bits, and shifts the outcome into the history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghbp_front
    import ghbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 busy,
    input  ghbp_q_status_t       q_stat,
    output logic                 push,
    output ghbp_entry_t          push_entry
);

    logic [HISTORY_BITS-1:0] hist_reg;
    logic [HISTORY_BITS-1:0] hist_next;
    logic                    taken;

    assign s_axis_tready = !busy && !q_stat.full;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign taken         = s_axis_tdata[32];

    assign push_entry.idx   = {hist_reg, s_axis_tdata[PC_INDEX_BITS-1:0]};
    assign push_entry.taken = taken;

    always_comb
    begin
        hist_next = hist_reg;
        if (push)
        begin
            hist_next = {hist_reg[HISTORY_BITS-2:0], taken};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '1;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

/* hw/rtl/ghbp_queue.sv */
// ----------------------------------------------------------------------------
// ghbp_queue
// Short FIFO of classified branches between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghbp_queue
    import ghbp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ghbp_entry_t    push_entry,
    input  logic           pop,
    output ghbp_entry_t    pop_entry,
    output ghbp_q_status_t q_stat
);

    ghbp_entry_t            store_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    assign pop_entry   = store_reg[rd_ptr_reg];
    assign q_stat.vld  = (count_reg != '0);
    assign q_stat.full = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{QUEUE_PTR_W{1'b0}}, push} - {{QUEUE_PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/ghbp_back.sv */
// ----------------------------------------------------------------------------
// ghbp_back
// Counter table with read-modify-write and forwarding, the clearing pass
// after reset, and the two-entry output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghbp_back
    import ghbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ghbp_q_status_t       q_stat,
    input  ghbp_entry_t          q_entry,
    output logic                 pop,
    output logic                 busy,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [1:0]            mem [TABLE_DEPTH];
    logic [1:0]            rdata_reg;

    logic                  clr_reg;
    logic                  clr_next;
    logic [TABLE_BITS-1:0] clr_idx_reg;
    logic [TABLE_BITS-1:0] clr_idx_next;

    logic                  b_vld_reg;
    logic                  b_vld_next;
    logic [TABLE_BITS-1:0] b_idx_reg;
    logic                  b_taken_reg;

    logic                  fwd_vld_reg;
    logic [TABLE_BITS-1:0] fwd_idx_reg;
    logic [1:0]            fwd_val_reg;

    logic [1:0]            obuf_reg [2];
    logic                  owr_ptr_reg;
    logic                  owr_ptr_next;
    logic                  ord_ptr_reg;
    logic                  ord_ptr_next;
    logic [1:0]            occ_reg;
    logic [1:0]            occ_next;
    logic [2:0]            occ_ahead;

    logic                  out_pop;
    logic [1:0]            cnt_cur;
    logic [1:0]            cnt_new;
    logic                  we;
    logic [TABLE_BITS-1:0] waddr;
    logic [1:0]            wdata;

    assign busy          = clr_reg;
    assign m_axis_tvalid = (occ_reg != 2'd0);
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, obuf_reg[ord_ptr_reg][1]};
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    // Occupancy the output buffer will have once the item now in the read
    // stage has been pushed; a new read is issued only if its result fits.
    assign occ_ahead = {1'b0, occ_reg} + {2'b0, b_vld_reg} - {2'b0, out_pop};
    assign pop       = q_stat.vld && !clr_reg && (occ_ahead <= 3'd1);

    assign cnt_cur = (fwd_vld_reg && (fwd_idx_reg == b_idx_reg)) ? fwd_val_reg : rdata_reg;
    assign cnt_new = ghbp_next_counter(cnt_cur, b_taken_reg);

    assign we    = clr_reg || b_vld_reg;
    assign waddr = clr_reg ? clr_idx_reg : b_idx_reg;
    assign wdata = clr_reg ? CNT_STRONG_T : cnt_new;

    always_comb
    begin
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        if (clr_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == {TABLE_BITS{1'b1}})
            begin
                clr_next = 1'b0;
            end
        end
        b_vld_next   = pop;
        owr_ptr_next = b_vld_reg ? !owr_ptr_reg : owr_ptr_reg;
        ord_ptr_next = out_pop ? !ord_ptr_reg : ord_ptr_reg;
        occ_next     = occ_reg + {1'b0, b_vld_reg} - {1'b0, out_pop};
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[q_entry.idx];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_idx_reg   <= q_entry.idx;
            b_taken_reg <= q_entry.taken;
        end
        fwd_idx_reg <= b_idx_reg;
        fwd_val_reg <= cnt_new;
        if (b_vld_reg)
        begin
            obuf_reg[owr_ptr_reg] <= cnt_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            b_vld_reg   <= 1'b0;
            fwd_vld_reg <= 1'b0;
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            occ_reg     <= 2'd0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
            b_vld_reg   <= b_vld_next;
            fwd_vld_reg <= b_vld_reg;
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            occ_reg     <= occ_next;
        end
    end

endmodule

/* hw/rtl/ghbp_checker.sv */
// ----------------------------------------------------------------------------
// ghbp_checker
// Port-level checks of the predictor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghbp_checker
    import ghbp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [3:0] outstanding_reg;
    logic [3:0] outstanding_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        outstanding_next = outstanding_reg + {3'b0, in_acc} - {3'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> outstanding_reg != 4'd0)
        else $error("result without a pending input transaction");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 4'd7)
        else $error("too many transactions in flight");

    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_axis_tready)
        else $error("input accepted before the table was cleared");

endmodule

bind global_history_branch_predictor_core ghbp_checker u_ghbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
